### hdl/servo_command_frame_encoder_core_defines.svh
// Assertion macros shared by the encoder RTL.
`ifndef SERVO_COMMAND_FRAME_ENCODER_CORE_DEFINES_SVH
`define SERVO_COMMAND_FRAME_ENCODER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define SCFE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scfe: property violated");
`define SCFE_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("scfe: forbidden condition seen");
`else
`define SCFE_ASSERT(lbl, clk, rst_n, prop)
`define SCFE_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### hdl/scfe_pkg.sv
package scfe_pkg;

    localparam int MAX_SERVO = 4;

    // servo 0 range limits, degrees
    localparam logic signed [15:0] ANG0_MAX = 16'sd81;
    localparam logic signed [15:0] ANG0_MIN = -16'sd54;
    localparam logic signed [16:0] ANG_OFFSET = 17'sd135;
    localparam logic signed [16:0] ANG_SPAN = 17'sd270;

    localparam logic [11:0] PULSE_MIN = 12'd500;
    localparam logic [11:0] PULSE_MAX = 12'd2500;
    localparam logic [13:0] TIME_MAX = 14'd9999;

    // x*200/27: 200 * ceil(2^20/27), result in bits 31:20, at most one too high
    localparam logic [31:0] PULSE_RECIP = 32'd7767400;
    localparam logic [15:0] PULSE_SCALE = 16'd200;
    localparam logic [16:0] PULSE_DIV = 17'd27;

    localparam logic [7:0] CH_BRACE_OPEN = 8'h7B;
    localparam logic [7:0] CH_BRACE_CLOSE = 8'h7D;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_BANG = 8'h21;

    // one frame request, digits already in BCD
    typedef struct packed {
        logic [MAX_SERVO-1:0]       mask;
        logic [MAX_SERVO-1:0][15:0] pulse_bcd;
        logic [15:0]                tm_bcd;
    } t_cmd;

endpackage

### hdl/servo_command_frame_encoder_core.sv
// Servo command frame encoder.
// Input queue side: push/full. A request carries four signed angles, an
// update mask and a move time; it is taken on a clock edge with push high
// and full low. Result queue side: empty/pop. Each result is one ASCII byte
// of the frame "{" + one "#00iPppppTtttt!" record per set mask bit + "}",
// with o_last_byte set on the closing brace. A byte is taken on an edge with
// pop high and empty low.
// The first byte of a frame passes the five-stage pulse/BCD pipeline, the
// command queue and the output register.
// The output gives one byte per cycle while the receiver pops; a frame is
// 2 + 15 * (set mask bits) bytes, 2 to 62; this serializer sets the rate.
// The front pipeline keeps accepting requests into a four-entry command
// queue while a frame is being sent. When the receiver stalls, the output
// byte holds, the queue fills and then full rises.
// Reset (synchronous, active low) empties the pipeline, the queue and the
// output register; no frame is in progress afterwards.
module servo_command_frame_encoder_core
    import scfe_pkg::*;
#(
    parameter int SERVO_COUNT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_angle_zero,
    input  logic [15:0] i_angle_one,
    input  logic [15:0] i_angle_two,
    input  logic [15:0] i_angle_three,
    input  logic [3:0]  i_update_mask,
    input  logic [13:0] i_move_time,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte
);

    t_cmd w_cmd_in;
    t_cmd w_cmd_out;
    logic w_cmd_push;
    logic w_cmd_full;
    logic w_cmd_pop;
    logic w_cmd_empty;

    scfe_front #(
        .SERVO_COUNT(SERVO_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_angle_zero (i_angle_zero),
        .i_angle_one  (i_angle_one),
        .i_angle_two  (i_angle_two),
        .i_angle_three(i_angle_three),
        .i_update_mask(i_update_mask),
        .i_move_time  (i_move_time),
        .o_cmd_push   (w_cmd_push),
        .o_cmd        (w_cmd_in),
        .i_cmd_full   (w_cmd_full)
    );

    scfe_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_cmd_push),
        .i_cmd  (w_cmd_in),
        .o_full (w_cmd_full),
        .i_pop  (w_cmd_pop),
        .o_empty(w_cmd_empty),
        .o_cmd  (w_cmd_out)
    );

    scfe_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_empty(w_cmd_empty),
        .i_cmd      (w_cmd_out),
        .o_cmd_pop  (w_cmd_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_byte (o_out_byte),
        .o_last_byte(o_last_byte)
    );

endmodule

### hdl/scfe_front.sv
module scfe_front
    import scfe_pkg::*;
#(
    parameter int SERVO_COUNT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [15:0] i_angle_zero,
    input  logic [15:0] i_angle_one,
    input  logic [15:0] i_angle_two,
    input  logic [15:0] i_angle_three,
    input  logic [3:0]  i_update_mask,
    input  logic [13:0] i_move_time,
    output logic        o_cmd_push,
    output t_cmd        o_cmd,
    input  logic        i_cmd_full
);

    // add-3/shift steps of double dabble over four BCD digits, seven bits per call
    function automatic logic [15:0] dd7(input logic [15:0] bcd_in, input logic [6:0] bits);
        logic [15:0] b;
        b = bcd_in;
        for (int j = 6; j >= 0; j--) begin
            for (int k = 0; k < 4; k++) begin
                if (b[4*k +: 4] >= 4'd5) begin
                    b[4*k +: 4] = b[4*k +: 4] + 4'd3;
                end
            end
            b = {b[14:0], bits[j]};
        end
        return b;
    endfunction

    logic [MAX_SERVO-1:0][15:0] w_angle;
    logic                       w_adv;

    logic [4:0]                 r_v;

    logic [MAX_SERVO-1:0][8:0]  r_s1_x, n_s1_x;
    logic [MAX_SERVO-1:0]       r_s1_lo, n_s1_lo;
    logic [MAX_SERVO-1:0]       r_s1_hi, n_s1_hi;
    logic [MAX_SERVO-1:0]       r_s1_mask, n_s1_mask;
    logic [13:0]                r_s1_time, n_s1_time;

    logic [MAX_SERVO-1:0][11:0] r_s2_q0, n_s2_q0;
    logic [MAX_SERVO-1:0][15:0] r_s2_n, n_s2_n;
    logic [MAX_SERVO-1:0]       r_s2_lo, r_s2_hi, r_s2_mask;
    logic [13:0]                r_s2_time;

    logic [MAX_SERVO-1:0][11:0] r_s3_p, n_s3_p;
    logic [MAX_SERVO-1:0]       r_s3_mask;
    logic [13:0]                r_s3_time;

    logic [MAX_SERVO-1:0][15:0] r_s4_bcd, n_s4_bcd;
    logic [MAX_SERVO-1:0][6:0]  r_s4_low, n_s4_low;
    logic [MAX_SERVO-1:0]       r_s4_mask;
    logic [15:0]                r_s4_tbcd, n_s4_tbcd;
    logic [6:0]                 r_s4_tlow, n_s4_tlow;

    logic [MAX_SERVO-1:0][15:0] r_s5_bcd, n_s5_bcd;
    logic [MAX_SERVO-1:0]       r_s5_mask;
    logic [15:0]                r_s5_tbcd, n_s5_tbcd;

    assign w_angle = {i_angle_three, i_angle_two, i_angle_one, i_angle_zero};

    // whole pipe holds while the last stage waits on a full queue
    assign w_adv  = !(r_v[4] && i_cmd_full);
    assign o_full = !w_adv;

    // stage 1: clamp servo 0 and move time, offset, range flags
    always_comb begin
        logic signed [15:0] a;
        logic signed [16:0] x;
        n_s1_x    = '0;
        n_s1_lo   = '0;
        n_s1_hi   = '0;
        n_s1_mask = '0;
        for (int i = 0; i < SERVO_COUNT; i++) begin
            a = $signed(w_angle[i]);
            if (i == 0) begin
                if (a > ANG0_MAX) begin
                    a = ANG0_MAX;
                end else if (a < ANG0_MIN) begin
                    a = ANG0_MIN;
                end
            end
            x = $signed({a[15], a}) + ANG_OFFSET;
            n_s1_lo[i]   = (x < 17'sd0);
            n_s1_hi[i]   = (x > ANG_SPAN);
            n_s1_x[i]    = x[8:0];
            n_s1_mask[i] = i_update_mask[i];
        end
        n_s1_time = (i_move_time > TIME_MAX) ? TIME_MAX : i_move_time;
    end

    // stage 2: reciprocal multiply, stage 3: fix-up and clamp
    always_comb begin
        logic [31:0] prod;
        logic [16:0] chk;
        logic [11:0] q;
        for (int i = 0; i < MAX_SERVO; i++) begin
            prod       = {23'd0, r_s1_x[i]} * PULSE_RECIP;
            n_s2_q0[i] = prod[31:20];
            n_s2_n[i]  = {7'd0, r_s1_x[i]} * PULSE_SCALE;

            chk = {5'd0, r_s2_q0[i]} * PULSE_DIV;
            q   = (chk > {1'b0, r_s2_n[i]}) ? (r_s2_q0[i] - 12'd1) : r_s2_q0[i];
            if (r_s2_lo[i]) begin
                n_s3_p[i] = PULSE_MIN;
            end else if (r_s2_hi[i]) begin
                n_s3_p[i] = PULSE_MAX;
            end else begin
                n_s3_p[i] = q + PULSE_MIN;
            end
        end
    end

    // stages 4 and 5: binary to BCD in two halves
    always_comb begin
        logic [13:0] p14;
        for (int i = 0; i < MAX_SERVO; i++) begin
            p14         = {2'b00, r_s3_p[i]};
            n_s4_bcd[i] = dd7(16'd0, p14[13:7]);
            n_s4_low[i] = p14[6:0];
            n_s5_bcd[i] = dd7(r_s4_bcd[i], r_s4_low[i]);
        end
        n_s4_tbcd = dd7(16'd0, r_s3_time[13:7]);
        n_s4_tlow = r_s3_time[6:0];
        n_s5_tbcd = dd7(r_s4_tbcd, r_s4_tlow);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[3:0], i_push};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_x    <= n_s1_x;
            r_s1_lo   <= n_s1_lo;
            r_s1_hi   <= n_s1_hi;
            r_s1_mask <= n_s1_mask;
            r_s1_time <= n_s1_time;

            r_s2_q0   <= n_s2_q0;
            r_s2_n    <= n_s2_n;
            r_s2_lo   <= r_s1_lo;
            r_s2_hi   <= r_s1_hi;
            r_s2_mask <= r_s1_mask;
            r_s2_time <= r_s1_time;

            r_s3_p    <= n_s3_p;
            r_s3_mask <= r_s2_mask;
            r_s3_time <= r_s2_time;

            r_s4_bcd  <= n_s4_bcd;
            r_s4_low  <= n_s4_low;
            r_s4_mask <= r_s3_mask;
            r_s4_tbcd <= n_s4_tbcd;
            r_s4_tlow <= n_s4_tlow;

            r_s5_bcd  <= n_s5_bcd;
            r_s5_mask <= r_s4_mask;
            r_s5_tbcd <= n_s5_tbcd;
        end
    end

    assign o_cmd_push      = r_v[4] && !i_cmd_full;
    assign o_cmd.mask      = r_s5_mask;
    assign o_cmd.pulse_bcd = r_s5_bcd;
    assign o_cmd.tm_bcd    = r_s5_tbcd;

endmodule

### hdl/scfe_fifo.sv
`include "servo_command_frame_encoder_core_defines.svh"

module scfe_fifo
    import scfe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int CMD_DEPTH = 4;
    localparam int PTR_W = $clog2(CMD_DEPTH);

    t_cmd             r_mem [CMD_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_full  = (r_count == (PTR_W+1)'(CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `SCFE_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full)
    `SCFE_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_empty)

endmodule

### hdl/scfe_back.sv
`include "servo_command_frame_encoder_core_defines.svh"

module scfe_back
    import scfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_empty,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic       o_last_byte
);

    // record layout "#00iPppppTtttt!"
    localparam logic [3:0] POS_HASH  = 4'd0;
    localparam logic [3:0] POS_ZERO0 = 4'd1;
    localparam logic [3:0] POS_ZERO1 = 4'd2;
    localparam logic [3:0] POS_ID    = 4'd3;
    localparam logic [3:0] POS_P     = 4'd4;
    localparam logic [3:0] POS_P3    = 4'd5;
    localparam logic [3:0] POS_P2    = 4'd6;
    localparam logic [3:0] POS_P1    = 4'd7;
    localparam logic [3:0] POS_P0    = 4'd8;
    localparam logic [3:0] POS_T     = 4'd9;
    localparam logic [3:0] POS_T3    = 4'd10;
    localparam logic [3:0] POS_T2    = 4'd11;
    localparam logic [3:0] POS_T1    = 4'd12;
    localparam logic [3:0] POS_T0    = 4'd13;
    localparam logic [3:0] POS_BANG  = 4'd14;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REC,
        ST_CLOSE
    } t_state;

    function automatic logic [1:0] lowest(input logic [MAX_SERVO-1:0] m);
        logic [1:0] r;
        r = '0;
        for (int i = MAX_SERVO - 1; i >= 0; i--) begin
            if (m[i]) begin
                r = 2'(i);
            end
        end
        return r;
    endfunction

    t_state               r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    logic [MAX_SERVO-1:0] r_rem, n_rem;
    logic [MAX_SERVO-1:0] w_rem_after;
    logic [1:0]           r_servo, n_servo;
    logic [3:0]           r_pos, n_pos;
    logic                 r_out_v, n_out_v;
    logic [7:0]           r_out_byte, n_out_byte;
    logic                 r_out_last, n_out_last;
    logic                 w_load;
    logic [7:0]           w_rec_byte;
    logic [15:0]          w_pulse;

    assign w_load      = !r_out_v || i_pop;
    assign w_rem_after = r_rem & ~(MAX_SERVO'(1) << r_servo);
    assign w_pulse     = r_cmd.pulse_bcd[r_servo];

    always_comb begin
        case (r_pos)
            POS_HASH:  w_rec_byte = CH_HASH;
            POS_ZERO0: w_rec_byte = CH_ZERO;
            POS_ZERO1: w_rec_byte = CH_ZERO;
            POS_ID:    w_rec_byte = CH_ZERO | {6'd0, r_servo};
            POS_P:     w_rec_byte = CH_P;
            POS_P3:    w_rec_byte = CH_ZERO | {4'd0, w_pulse[15:12]};
            POS_P2:    w_rec_byte = CH_ZERO | {4'd0, w_pulse[11:8]};
            POS_P1:    w_rec_byte = CH_ZERO | {4'd0, w_pulse[7:4]};
            POS_P0:    w_rec_byte = CH_ZERO | {4'd0, w_pulse[3:0]};
            POS_T:     w_rec_byte = CH_T;
            POS_T3:    w_rec_byte = CH_ZERO | {4'd0, r_cmd.tm_bcd[15:12]};
            POS_T2:    w_rec_byte = CH_ZERO | {4'd0, r_cmd.tm_bcd[11:8]};
            POS_T1:    w_rec_byte = CH_ZERO | {4'd0, r_cmd.tm_bcd[7:4]};
            POS_T0:    w_rec_byte = CH_ZERO | {4'd0, r_cmd.tm_bcd[3:0]};
            POS_BANG:  w_rec_byte = CH_BANG;
            default:   w_rec_byte = CH_BANG;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_rem      = r_rem;
        n_servo    = r_servo;
        n_pos      = r_pos;
        n_out_v    = r_out_v && !i_pop;
        n_out_byte = r_out_byte;
        n_out_last = r_out_last;
        o_cmd_pop  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_load && !i_cmd_empty) begin
                    o_cmd_pop  = 1'b1;
                    n_cmd      = i_cmd;
                    n_rem      = i_cmd.mask;
                    n_servo    = lowest(i_cmd.mask);
                    n_pos      = POS_HASH;
                    n_out_v    = 1'b1;
                    n_out_byte = CH_BRACE_OPEN;
                    n_out_last = 1'b0;
                    n_state    = (i_cmd.mask == '0) ? ST_CLOSE : ST_REC;
                end
            end
            ST_REC: begin
                if (w_load) begin
                    n_out_v    = 1'b1;
                    n_out_byte = w_rec_byte;
                    n_out_last = 1'b0;
                    if (r_pos == POS_BANG) begin
                        n_pos   = POS_HASH;
                        n_rem   = w_rem_after;
                        n_servo = lowest(w_rem_after);
                        n_state = (w_rem_after == '0) ? ST_CLOSE : ST_REC;
                    end else begin
                        n_pos = r_pos + 4'd1;
                    end
                end
            end
            ST_CLOSE: begin
                if (w_load) begin
                    n_out_v    = 1'b1;
                    n_out_byte = CH_BRACE_CLOSE;
                    n_out_last = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= POS_HASH;
            r_out_v <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_out_v    <= n_out_v;
            r_cmd      <= n_cmd;
            r_rem      <= n_rem;
            r_servo    <= n_servo;
            r_out_byte <= n_out_byte;
            r_out_last <= n_out_last;
        end
    end

    assign o_empty     = !r_out_v;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_out_last;

    `SCFE_ASSERT(a_rec_servo_pending, i_clk, i_rst_n, (r_state == ST_REC) |-> r_rem[r_servo])
    `SCFE_NEVER(a_pos_in_record, i_clk, i_rst_n, r_pos > POS_BANG)
    `SCFE_ASSERT(a_close_ends_frame, i_clk, i_rst_n, (r_state == ST_CLOSE) && w_load |=> (r_state == ST_IDLE) && r_out_last)

endmodule
